FILE: sv/c2p_pkg.sv
// shared constants, types and the cordic micro-rotation for the cartesian to polar converter
// no dependencies; imported by cartesian_to_polar
`default_nettype none

package c2p_pkg;

   // default widths of the coordinate and angle fields
   localparam int COORD_WIDTH_DEF = 16;
   localparam int ANGLE_WIDTH_DEF = 16;

   // cordic datapath: offsets scaled to a fixed number of fraction bits
   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_W     = 64;
   localparam int CORDIC_FRAC  = 60;
   localparam int TURN_W       = 32;

   // arctangents of 2^-i in units of 2^-32 turn
   localparam logic [TURN_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_X = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_Y = 1'b1;

   // how the angle of an item is settled
   typedef enum logic [2:0] {
      ANG_ZERO,
      ANG_POS_Y,
      ANG_NEG_Y,
      ANG_POS_X,
      ANG_NEG_X,
      ANG_CORDIC
   } ang_case_type;

   // cordic vector and turn accumulator
   typedef struct packed {
      logic [CORDIC_W-1:0] x;
      logic [CORDIC_W-1:0] y;
      logic [TURN_W-1:0]   z;
   } cordic_type;

   // one vectoring micro-rotation; shifts round toward minus infinity
   function automatic cordic_type cordic_step(cordic_type s, int unsigned sh,
                                              logic [TURN_W-1:0] at);
      logic signed [CORDIC_W-1:0] xv;
      logic signed [CORDIC_W-1:0] yv;
      logic signed [CORDIC_W-1:0] xs;
      logic signed [CORDIC_W-1:0] ys;
      cordic_type r;
      xv = s.x;
      yv = s.y;
      xs = xv >>> sh;
      ys = yv >>> sh;
      if (yv > 0) begin
         r.x = xv + ys;
         r.y = yv - xs;
         r.z = s.z + at;
      end else begin
         r.x = xv - ys;
         r.y = yv + xs;
         r.z = s.z - at;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: sv/cartesian_to_polar.sv
// cartesian to polar converter: centre offset, pipelined square root and cordic angle
// depends on c2p_pkg
`default_nettype none

// pipeline: offset stage a, stage b, stages 0..NITER (micro-rotations and root bits), then the output register
//    drives rsp_strobe; with the default widths the depth is set by the 30 cordic micro-rotation stages
// throughput: one item per cycle; busy stays low, every stage advances each cycle
// results appear for one cycle only, the receiver cannot stall the pipeline
// reset clears the valid bits of every stage and both centre registers to 0

module cartesian_to_polar #(
   parameter int COORD_WIDTH = c2p_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH = c2p_pkg::ANGLE_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // input items
   input  logic                            start,
   output logic                            busy,
   input  logic [7:0]                      req_blob_id,
   input  logic [COORD_WIDTH-1:0]          req_x_position,
   input  logic [COORD_WIDTH-1:0]          req_y_position,
   // results
   output logic                            rsp_strobe,
   output logic [7:0]                      rsp_out_blob_id,
   output logic [COORD_WIDTH:0]            rsp_radius,
   output logic [ANGLE_WIDTH-1:0]          rsp_angle,
   // configuration
   input  logic                            csr_write_enable,
   input  logic [c2p_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]          csr_write_data
);
   import c2p_pkg::*;

   localparam int DW        = COORD_WIDTH + 1;
   localparam int SQ_W      = 2 * COORD_WIDTH + 2;
   localparam int ROOT_BITS = COORD_WIDTH + 1;
   localparam int REM_W     = ROOT_BITS + 3;
   localparam int SH        = CORDIC_FRAC - COORD_WIDTH;
   localparam int NITER     = (CORDIC_STEPS - 1 > ROOT_BITS) ? CORDIC_STEPS - 1 : ROOT_BITS;

   localparam logic [ANGLE_WIDTH-1:0] ANG_QUARTER = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
   localparam logic [ANGLE_WIDTH-1:0] ANG_THREE_Q = ANGLE_WIDTH'(3) << (ANGLE_WIDTH - 2);
   localparam logic [ANGLE_WIDTH-1:0] ANG_HALF    = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1);
   localparam logic [TURN_W-1:0]      ANG_RND     = TURN_W'(1) << (TURN_W - 1 - ANGLE_WIDTH);

   // every item is taken at once
   assign busy = 1'b0;

   // centre registers
   logic [COORD_WIDTH-1:0] center_x_ff;
   logic [COORD_WIDTH-1:0] center_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_write_data;
            CSR_CENTER_Y: center_y_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // stage a: offset from the centre
   logic                 va_ff;
   logic [7:0]           blob_a_ff;
   logic signed [DW-1:0] dx_ff;
   logic signed [DW-1:0] dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= start & ~busy;
      end
      blob_a_ff <= req_blob_id;
      dx_ff     <= $signed({1'b0, req_x_position}) - $signed({1'b0, center_x_ff});
      dy_ff     <= $signed({1'b0, req_y_position}) - $signed({1'b0, center_y_ff});
   end

   // stage b: magnitudes, squares, angle case and cordic start vector
   logic [DW-1:0]            ax_full;
   logic [DW-1:0]            ay_full;
   logic [COORD_WIDTH-1:0]   ax;
   logic [COORD_WIDTH-1:0]   ay;
   logic                     yneg;
   logic [CORDIC_W-1:0]      yi;
   ang_case_type             case_in;
   cordic_type               cb_in;

   always_comb begin
      ax_full = dx_ff[DW-1] ? DW'(-dx_ff) : DW'(dx_ff);
      ay_full = dy_ff[DW-1] ? DW'(-dy_ff) : DW'(dy_ff);
      ax      = ax_full[COORD_WIDTH-1:0];
      ay      = ay_full[COORD_WIDTH-1:0];
      yneg    = dx_ff[DW-1] ^ dy_ff[DW-1];
      yi      = CORDIC_W'(ay) << SH;
      cb_in.x = CORDIC_W'(ax) << SH;
      cb_in.y = yneg ? -yi : yi;
      cb_in.z = dx_ff[DW-1] ? {1'b1, {(TURN_W - 1){1'b0}}} : '0;
      priority if (dx_ff == '0 && dy_ff == '0) begin
         case_in = ANG_ZERO;
      end else if (dx_ff == '0 && !dy_ff[DW-1]) begin
         case_in = ANG_POS_Y;
      end else if (dx_ff == '0) begin
         case_in = ANG_NEG_Y;
      end else if (dy_ff == '0 && !dx_ff[DW-1]) begin
         case_in = ANG_POS_X;
      end else if (dy_ff == '0) begin
         case_in = ANG_NEG_X;
      end else begin
         case_in = ANG_CORDIC;
      end
   end

   logic                       vb_ff;
   logic [7:0]                 blob_b_ff;
   logic [2*COORD_WIDTH-1:0]   a2_ff;
   logic [2*COORD_WIDTH-1:0]   b2_ff;
   ang_case_type               case_b_ff;
   cordic_type                 cb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
      end
      blob_b_ff <= blob_a_ff;
      a2_ff     <= (2*COORD_WIDTH)'(ax) * (2*COORD_WIDTH)'(ax);
      b2_ff     <= (2*COORD_WIDTH)'(ay) * (2*COORD_WIDTH)'(ay);
      case_b_ff <= case_in;
      cb_ff     <= cb_in;
   end

   // stage arrays: index 0 holds the sum and the first micro-rotation
   logic               vld_ff  [NITER+1];
   logic [7:0]         blob_ff [NITER+1];
   ang_case_type       case_ff [NITER+1];
   cordic_type         cor_ff  [NITER+1];
   logic [SQ_W-1:0]    rad_ff  [NITER+1];
   logic [REM_W-1:0]   rem_ff  [NITER+1];
   logic [ROOT_BITS-1:0] root_ff [NITER+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= vb_ff;
      end
      blob_ff[0] <= blob_b_ff;
      case_ff[0] <= case_b_ff;
      cor_ff[0]  <= cordic_step(cb_ff, 0, ATAN_TURNS[0]);
      rad_ff[0]  <= SQ_W'(a2_ff) + SQ_W'(b2_ff);
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
   end

   // stages 1..NITER: a micro-rotation while j < CORDIC_STEPS and a root bit while j <= ROOT_BITS, else pass on
   for (genvar j = 1; j <= NITER; j++) begin : g_stage
      cordic_type           rot;
      logic [SQ_W-1:0]      rad_in;
      logic [REM_W-1:0]     rem_in;
      logic [ROOT_BITS-1:0] root_in;

      if (j < CORDIC_STEPS) begin : g_rot
         assign rot = cordic_step(cor_ff[j-1], j, ATAN_TURNS[j]);
      end else begin : g_rot_hold
         assign rot = cor_ff[j-1];
      end

      if (j <= ROOT_BITS) begin : g_sqrt
         logic [REM_W-1:0] rem_sh;
         logic [REM_W-1:0] trial;
         // restoring square root, two radicand bits per stage
         always_comb begin
            rem_sh = {rem_ff[j-1][REM_W-3:0], rad_ff[j-1][SQ_W-1 -: 2]};
            trial  = {1'b0, root_ff[j-1], 2'b01};
            rad_in = {rad_ff[j-1][SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[j-1][ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[j-1][ROOT_BITS-2:0], 1'b0};
            end
         end
      end else begin : g_sqrt_hold
         assign rad_in  = rad_ff[j-1];
         assign rem_in  = rem_ff[j-1];
         assign root_in = root_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_ff[j-1];
         end
         blob_ff[j] <= blob_ff[j-1];
         case_ff[j] <= case_ff[j-1];
         cor_ff[j]  <= rot;
         rad_ff[j]  <= rad_in;
         rem_ff[j]  <= rem_in;
         root_ff[j] <= root_in;
      end
   end

   // final stage: round radius and angle, pick axis angles
   logic [TURN_W-1:0]      z_rnd;
   logic [ROOT_BITS-1:0]   radius_in;
   logic [ANGLE_WIDTH-1:0] angle_in;

   always_comb begin
      z_rnd     = cor_ff[NITER].z + ANG_RND;
      radius_in = (rem_ff[NITER] > REM_W'(root_ff[NITER])) ? root_ff[NITER] + ROOT_BITS'(1)
                                                         : root_ff[NITER];
      unique case (case_ff[NITER])
         ANG_ZERO:   angle_in = '0;
         ANG_POS_Y:  angle_in = ANG_QUARTER;
         ANG_NEG_Y:  angle_in = ANG_THREE_Q;
         ANG_POS_X:  angle_in = '0;
         ANG_NEG_X:  angle_in = ANG_HALF;
         ANG_CORDIC: angle_in = z_rnd[TURN_W-1 -: ANGLE_WIDTH];
         default:    angle_in = '0;
      endcase
   end

   logic                   rsp_strobe_ff;
   logic [7:0]             rsp_blob_ff;
   logic [COORD_WIDTH:0]   rsp_radius_ff;
   logic [ANGLE_WIDTH-1:0] rsp_angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= vld_ff[NITER];
      end
      rsp_blob_ff   <= blob_ff[NITER];
      rsp_radius_ff <= radius_in;
      rsp_angle_ff  <= angle_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_out_blob_id = rsp_blob_ff;
   assign rsp_radius      = rsp_radius_ff;
   assign rsp_angle       = rsp_angle_ff;

`ifndef SYNTHESIS
   // a zero offset leaves a zero radius and a zero angle
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NITER] && case_ff[NITER] == ANG_ZERO) |=>
         (rsp_radius == '0 && rsp_angle == '0))
      else $error("zero offset gave a non-zero result");

   // restoring root leaves a remainder of at most twice the root
   a_root_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NITER] |-> (rem_ff[NITER] <= REM_W'({root_ff[NITER], 1'b0})))
      else $error("square root remainder out of range");

   // positive y axis gives exactly a quarter turn
   a_pos_y: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NITER] && case_ff[NITER] == ANG_POS_Y) |=>
         (rsp_strobe && rsp_angle == ANG_QUARTER))
      else $error("positive y axis angle wrong");
`endif

endmodule

`default_nettype wire
